>>> rtl/core/cms_pkg.sv
`default_nettype none

package cms_pkg;

  localparam int unsigned FRAME_LEN   = 44;
  localparam int unsigned ROOT_LEN    = 32;
  localparam int unsigned MARK_LEN    = 4;
  localparam int unsigned CAPTURE_LEN = FRAME_LEN - MARK_LEN;
  localparam int unsigned WIN_LEN     = MARK_LEN - 1;
  localparam int unsigned ROOT_WORDS  = ROOT_LEN / 8;
  localparam int unsigned CNT_W       = $clog2(CAPTURE_LEN + 1);

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    PH_SEARCH  = 3'b001,
    PH_CAPTURE = 3'b010,
    PH_DONE    = 3'b100
  } scan_phase_t;

  // Outcome of one record, handed from the scanner to the result buffer
  typedef struct packed {
    logic                         found;
    logic [ROOT_WORDS-1:0][63:0]  root;
    logic [31:0]                  size;
    logic [31:0]                  nonce;
  } rec_result_t;

endpackage

`default_nettype wire

>>> rtl/core/cms_cell.sv
`default_nettype none

module cms_cell (
  input  wire logic            clk,
  input  wire logic            shift,
  input  wire cms_pkg::byte_t  d,
  output cms_pkg::byte_t       q
);

  cms_pkg::byte_t held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= d;
    end
  end

  assign q = held;

endmodule

`default_nettype wire

>>> rtl/core/cms_result_buf.sv
`default_nettype none

module cms_result_buf (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire cms_pkg::rec_result_t  rec,
  output logic                       free,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       found,
  output logic [63:0]                root_word,
  output logic [1:0]                 word_index,
  output logic [31:0]                size_field,
  output logic [31:0]                nonce_field,
  output logic                       last_result
);

  logic        valid;
  logic [1:0]  beat;
  logic        hit;
  logic [63:0] root [cms_pkg::ROOT_WORDS];
  logic [31:0] size;
  logic [31:0] nonce;
  logic        fire;

  assign fire        = valid && out_ready;
  assign last_result = !hit || (beat == 2'(cms_pkg::ROOT_WORDS - 1));
  assign free        = !valid || (out_ready && last_result);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      beat  <= '0;
    end else if (load) begin
      valid <= 1'b1;
      beat  <= '0;
    end else if (fire) begin
      if (last_result) begin
        valid <= 1'b0;
      end else begin
        beat <= beat + 2'd1;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (load) begin
      hit   <= rec.found;
      size  <= rec.size;
      nonce <= rec.nonce;
      for (int k = 0; k < cms_pkg::ROOT_WORDS; k++) begin
        root[k] <= rec.root[k];
      end
    end
  end

  assign out_valid   = valid;
  assign found       = hit;
  assign word_index  = hit ? beat : 2'd0;
  assign root_word   = hit ? root[beat] : 64'd0;
  assign size_field  = hit ? size : 32'd0;
  assign nonce_field = hit ? nonce : 32'd0;

endmodule

`default_nettype wire

>>> rtl/core/commitment_marker_scanner_top.sv
`default_nettype none
// The results of a record appear in the cycle after its marked last byte is accepted.
// Throughput: one byte per cycle; a record with a commitment gives four result beats,
// otherwise one. A last byte waits only while the previous record's results still drain.
// Reset (synchronous, active high): marker register to zero, scan back to searching,
// result buffer empty. Captured bytes are not cleared; they are read only once complete.

module commitment_marker_scanner_top (
  input  wire logic         clk,
  input  wire logic         rst,
  // configuration: marker word
  input  wire logic         cfg_write_en,
  input  wire logic [31:0]  cfg_write_data,
  // byte requests
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   data_byte,
  input  wire logic         last_byte,
  // result requests
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              found,
  output logic [63:0]       root_word,
  output logic [1:0]        word_index,
  output logic [31:0]       size_field,
  output logic [31:0]       nonce_field,
  output logic              last_result
);

  localparam int unsigned NCAP = cms_pkg::CAPTURE_LEN;
  localparam int unsigned NWIN = cms_pkg::WIN_LEN;

  logic [31:0]               magic;
  cms_pkg::scan_phase_t      phase, phase_next;
  logic [1:0]                seen, seen_next;
  logic [cms_pkg::CNT_W-1:0] count, count_next;

  logic                 accept;
  logic                 match;
  logic                 win_shift;
  logic                 cap_shift;
  logic                 done_now;
  logic                 buf_free;
  cms_pkg::byte_t       win_q [NWIN];
  cms_pkg::byte_t       cap_q [NCAP];
  cms_pkg::byte_t       cap_byte [NCAP];
  cms_pkg::rec_result_t rec;

  // Accept ordinary bytes always; a last byte needs room in the result buffer
  assign in_ready = !last_byte || buf_free;
  assign accept   = in_valid && in_ready;

  // Marker register: later compares use the new value at once
  always_ff @(posedge clk) begin
    if (rst) begin
      magic <= '0;
    end else if (cfg_write_en) begin
      magic <= cfg_write_data;
    end
  end

  // Search window: cell 0 holds the newest of the three previous bytes
  assign win_shift = accept && (phase == cms_pkg::PH_SEARCH);

  for (genvar i = 0; i < NWIN; i++) begin : g_win
    cms_cell u_cell (
      .clk   (clk),
      .shift (win_shift),
      .d     ((i == 0) ? data_byte : win_q[(i == 0) ? 0 : i - 1]),
      .q     (win_q[i])
    );
  end

  // Marker starts three bytes back and ends with the incoming byte
  assign match = (phase == cms_pkg::PH_SEARCH) && (seen == 2'd3) &&
                 (magic == {data_byte, win_q[0], win_q[1], win_q[2]});

  // Capture chain: bytes enter at cell 0 and advance one cell per capture,
  // so after the full capture cell NCAP-1 holds the first byte after the marker
  assign cap_shift = accept && (phase == cms_pkg::PH_CAPTURE);

  for (genvar i = 0; i < NCAP; i++) begin : g_cap
    cms_cell u_cell (
      .clk   (clk),
      .shift (cap_shift),
      .d     ((i == 0) ? data_byte : cap_q[(i == 0) ? 0 : i - 1]),
      .q     (cap_q[i])
    );
  end

  // Capture complete once this byte is taken, or already complete in the done phase
  assign done_now = (phase == cms_pkg::PH_DONE) ||
                    ((phase == cms_pkg::PH_CAPTURE) &&
                     (count == cms_pkg::CNT_W'(NCAP - 1)));

  // Captured bytes in record order, including the incoming byte when it is the final one
  always_comb begin
    for (int i = 0; i < NCAP; i++) begin
      if (phase == cms_pkg::PH_DONE) begin
        cap_byte[i] = cap_q[NCAP - 1 - i];
      end else if (i == NCAP - 1) begin
        cap_byte[i] = data_byte;
      end else begin
        cap_byte[i] = cap_q[NCAP - 2 - i];
      end
    end
  end

  // Root bytes first, then size and nonce, both little endian
  always_comb begin
    rec.found = done_now;
    for (int k = 0; k < cms_pkg::ROOT_WORDS; k++) begin
      for (int j = 0; j < 8; j++) begin
        rec.root[k][8*j +: 8] = cap_byte[8*k + j];
      end
    end
    for (int j = 0; j < 4; j++) begin
      rec.size[8*j +: 8]  = cap_byte[cms_pkg::ROOT_LEN + j];
      rec.nonce[8*j +: 8] = cap_byte[cms_pkg::ROOT_LEN + 4 + j];
    end
  end

  // Scan control
  always_comb begin
    phase_next = phase;
    seen_next  = seen;
    count_next = count;
    if (accept) begin
      if (last_byte) begin
        // drop per-record state for the next record
        phase_next = cms_pkg::PH_SEARCH;
        seen_next  = '0;
        count_next = '0;
      end else begin
        unique case (phase)
          cms_pkg::PH_SEARCH: begin
            if (seen != 2'd3) begin
              seen_next = seen + 2'd1;
            end
            if (match) begin
              phase_next = cms_pkg::PH_CAPTURE;
              count_next = '0;
            end
          end
          cms_pkg::PH_CAPTURE: begin
            count_next = count + cms_pkg::CNT_W'(1);
            if (done_now) begin
              phase_next = cms_pkg::PH_DONE;
            end
          end
          cms_pkg::PH_DONE: begin
            // hold: later bytes are ignored
          end
          default: begin
            phase_next = cms_pkg::PH_SEARCH;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= cms_pkg::PH_SEARCH;
      seen  <= '0;
      count <= '0;
    end else begin
      phase <= phase_next;
      seen  <= seen_next;
      count <= count_next;
    end
  end

  // Result buffer: parts the byte side from the result side
  cms_result_buf u_result_buf (
    .clk         (clk),
    .rst         (rst),
    .load        (accept && last_byte),
    .rec         (rec),
    .free        (buf_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .root_word   (root_word),
    .word_index  (word_index),
    .size_field  (size_field),
    .nonce_field (nonce_field),
    .last_result (last_result)
  );

endmodule

`default_nettype wire

>>> rtl/core/cms_checker.sv
`default_nettype none

module cms_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         out_valid,
  input wire logic         out_ready,
  input wire logic         found,
  input wire logic [63:0]  root_word,
  input wire logic [1:0]   word_index,
  input wire logic [31:0]  size_field,
  input wire logic [31:0]  nonce_field,
  input wire logic         last_result
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(root_word) &&
      $stable(word_index) && $stable(size_field) && $stable(nonce_field) &&
      $stable(last_result))
    else $error("result changed while stalled");

  // A miss is a single zeroed result
  a_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> last_result && word_index == 2'd0 && root_word == 64'd0 &&
      size_field == 32'd0 && nonce_field == 32'd0)
    else $error("not-found result malformed");

  // A hit ends exactly on word three
  a_hit_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> last_result == (word_index == 2'd3))
    else $error("hit result marks the wrong final word");

  // Words of a hit follow one another without a gap in the record
  a_hit_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && found && !last_result |=>
      out_valid && found && word_index == 2'($past(word_index) + 2'd1))
    else $error("hit words out of order");

endmodule

bind commitment_marker_scanner_top cms_checker u_cms_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .found       (found),
  .root_word   (root_word),
  .word_index  (word_index),
  .size_field  (size_field),
  .nonce_field (nonce_field),
  .last_result (last_result)
);

`default_nettype wire
